### rtl/core/fba_pkg.sv
// Shared types, constants and codes of the frame bitmap allocator.
`default_nettype none
package fba_pkg;

	localparam int NUM_FRAMES   = 4096;
	localparam int WORD_BITS    = 32;
	localparam int FIELD_FRAMES = 4096;
	localparam int NUM_WORDS    = (NUM_FRAMES + WORD_BITS - 1) / WORD_BITS;
	localparam int SCAN_LIMIT   = (NUM_FRAMES < FIELD_FRAMES) ? NUM_FRAMES : FIELD_FRAMES;
	localparam int WADDR_W      = $clog2(NUM_WORDS);
	localparam int WCNT_W       = WADDR_W + 1;
	localparam int BIT_IDX_W    = $clog2(WORD_BITS);
	localparam int FRAME_W      = 12;
	localparam int FCNT_W       = 13;

	localparam logic [FCNT_W-1:0] FRAME_COUNT_RESET = 13'd4096;

	localparam logic [1:0] ACT_ALLOC_FIRST = 2'd0;
	localparam logic [1:0] ACT_ALLOC_GIVEN = 2'd1;
	localparam logic [1:0] ACT_FREE        = 2'd2;

	localparam logic [1:0] STATUS_DONE    = 2'd0;
	localparam logic [1:0] STATUS_SKIPPED = 2'd1;
	localparam logic [1:0] STATUS_NO_FREE = 2'd2;

	typedef logic [WORD_BITS-1:0] word_t;

	typedef struct packed {
		logic [1:0]         action;
		logic [FRAME_W-1:0] current_frame;
		logic [FRAME_W-1:0] given_frame;
		logic               kernel_page;
		logic               rw_request;
	} req_t;

	typedef struct packed {
		logic [FRAME_W-1:0] new_frame;
		logic               present;
		logic               writable;
		logic               user_page;
		logic [1:0]         status;
	} rsp_t;

	typedef struct packed {
		logic               rd_en;
		logic [WADDR_W-1:0] rd_addr;
		logic               wr_en;
		logic [WADDR_W-1:0] wr_addr;
		word_t              wr_data;
	} mem_req_t;

endpackage
`default_nettype wire

### rtl/core/fba_bitmap_mem.sv
// Usage bitmap memory: one word per row, registered read, per-row valid bits.
`default_nettype none
module fba_bitmap_mem (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire fba_pkg::mem_req_t req,
	output fba_pkg::word_t        rd_data
);
	import fba_pkg::*;

	word_t                mem [NUM_WORDS];
	logic [NUM_WORDS-1:0] valid_q;
	word_t                rd_data_q;

	// A row never written reads as all free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (req.wr_en) begin
			valid_q[req.wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_data_q <= valid_q[req.rd_addr] ? mem[req.rd_addr] : '0;
		end
	end

	assign rd_data = rd_data_q;

endmodule
`default_nettype wire

### rtl/core/fba_engine.sv
// Allocation sequencer: bitmap scan, read-modify-write and result register.
`default_nettype none
module fba_engine (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic [fba_pkg::FCNT_W-1:0]  frame_count,
	input  wire logic                        req_valid,
	output logic                             req_stall,
	input  wire fba_pkg::req_t               req,
	output logic                             res_valid,
	input  wire logic                        res_stall,
	output fba_pkg::rsp_t                    res,
	output fba_pkg::mem_req_t                mem_req,
	input  wire fba_pkg::word_t              mem_rd_data
);
	import fba_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_WR   = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	function automatic logic [BIT_IDX_W-1:0] lowest_bit(input word_t w);
		logic [BIT_IDX_W-1:0] idx;
		idx = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (w[i]) idx = BIT_IDX_W'(i);
		end
		return idx;
	endfunction

	logic [1:0]           state_q;
	req_t                 item_q;
	rsp_t                 res_q;
	logic [WCNT_W-1:0]    words_q;
	logic [BIT_IDX_W-1:0] part_q;
	logic [WCNT_W-1:0]    scan_w_q;
	logic [WADDR_W-1:0]   chk_w_q;
	logic                 chk_v_q;
	logic                 set_q;
	logic [WADDR_W-1:0]   wadr_q;
	logic [BIT_IDX_W-1:0] bidx_q;
	logic                 inrng_q;

	logic                 accept;
	logic                 issue;
	logic [FCNT_W-1:0]    lim;
	logic [FRAME_W-1:0]   rmw_frame;
	logic                 rmw_need;
	logic [WADDR_W-1:0]   rmw_addr;
	logic                 last_word;
	word_t                word_mask;
	word_t                free_w;
	logic                 found;
	logic [BIT_IDX_W-1:0] fidx;
	word_t                wr_bit;

	assign accept    = req_valid && (state_q == ST_IDLE);
	assign req_stall = (state_q != ST_IDLE);
	assign res_valid = (state_q == ST_DONE);
	assign res       = res_q;

	assign lim = (frame_count > FCNT_W'(SCAN_LIMIT)) ? FCNT_W'(SCAN_LIMIT) : frame_count;

	assign rmw_frame = (req.action == ACT_ALLOC_GIVEN) ? req.given_frame : req.current_frame;
	assign rmw_need  = ((req.action == ACT_ALLOC_GIVEN) && (req.current_frame == '0)) ||
	                   ((req.action == ACT_FREE) && (req.current_frame != '0));
	assign rmw_addr  = WADDR_W'(rmw_frame >> BIT_IDX_W);

	assign issue = (state_q == ST_SCAN) && (scan_w_q < words_q);

	// Trim the final partial word to the scan limit
	assign last_word = (WCNT_W'(chk_w_q) == words_q - WCNT_W'(1));
	assign word_mask = (last_word && (part_q != '0)) ?
	                   (word_t'(1) << part_q) - word_t'(1) : '1;
	assign free_w    = ~mem_rd_data & word_mask;
	assign found     = chk_v_q && (free_w != '0);
	assign fidx      = lowest_bit(free_w);
	assign wr_bit    = word_t'(1) << ((state_q == ST_WR) ? bidx_q : fidx);

	always_comb begin
		mem_req         = '0;
		mem_req.rd_en   = (accept && rmw_need) || issue;
		mem_req.rd_addr = accept ? rmw_addr : scan_w_q[WADDR_W-1:0];
		if ((state_q == ST_SCAN) && found) begin
			mem_req.wr_en   = 1'b1;
			mem_req.wr_addr = chk_w_q;
			mem_req.wr_data = mem_rd_data | wr_bit;
		end else if ((state_q == ST_WR) && inrng_q) begin
			mem_req.wr_en   = 1'b1;
			mem_req.wr_addr = wadr_q;
			mem_req.wr_data = set_q ? (mem_rd_data | wr_bit) : (mem_rd_data & ~wr_bit);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			chk_v_q  <= 1'b0;
			scan_w_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						scan_w_q <= '0;
						chk_v_q  <= 1'b0;
						if ((req.action == ACT_ALLOC_FIRST) && (req.current_frame == '0)) begin
							state_q <= ST_SCAN;
						end else if (rmw_need) begin
							state_q <= ST_WR;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_SCAN: begin
					chk_v_q <= issue;
					if (issue) scan_w_q <= scan_w_q + WCNT_W'(1);
					if (found || !issue) state_q <= ST_DONE;
				end
				ST_WR: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!res_stall) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q  <= req;
			words_q <= WCNT_W'((lim + FCNT_W'(WORD_BITS - 1)) >> BIT_IDX_W);
			part_q  <= lim[BIT_IDX_W-1:0];
			set_q   <= (req.action == ACT_ALLOC_GIVEN);
			wadr_q  <= rmw_addr;
			bidx_q  <= rmw_frame[BIT_IDX_W-1:0];
			inrng_q <= (32'(rmw_frame) < NUM_FRAMES);
			if ((req.action == ACT_ALLOC_GIVEN) && (req.current_frame == '0)) begin
				res_q.new_frame <= req.given_frame;
				res_q.present   <= 1'b1;
				res_q.writable  <= req.rw_request;
				res_q.user_page <= !req.kernel_page;
				res_q.status    <= STATUS_DONE;
			end else if ((req.action == ACT_FREE) && (req.current_frame != '0)) begin
				res_q.new_frame <= '0;
				res_q.present   <= 1'b0;
				res_q.writable  <= 1'b0;
				res_q.user_page <= 1'b0;
				res_q.status    <= STATUS_DONE;
			end else begin
				res_q.new_frame <= req.current_frame;
				res_q.present   <= 1'b0;
				res_q.writable  <= 1'b0;
				res_q.user_page <= 1'b0;
				res_q.status    <= STATUS_SKIPPED;
			end
		end
		if (state_q == ST_SCAN) begin
			chk_w_q <= scan_w_q[WADDR_W-1:0];
			if (found) begin
				res_q.new_frame <= FRAME_W'({chk_w_q, fidx});
				res_q.present   <= 1'b1;
				res_q.writable  <= item_q.rw_request;
				res_q.user_page <= !item_q.kernel_page;
				res_q.status    <= STATUS_DONE;
			end else if (!issue) begin
				res_q.new_frame <= item_q.current_frame;
				res_q.status    <= STATUS_NO_FREE;
			end
		end
	end

endmodule
`default_nettype wire

### rtl/core/frame_bitmap_allocator.sv
// Top level of the frame bitmap allocator: config register, output register, wiring.
//
// Usage
//   Request channel (req_valid / req_stall / req) carries one transaction per
//   page-entry action: allocate first free frame, allocate a given frame, or
//   free the entry's frame. Response channel (rsp_valid / rsp_stall / rsp)
//   returns exactly one transaction per request, in order.
//   cfg_wr_en / cfg_wr_data write frame_count; write it only while idle.
// Sequencing
//   The engine works on one request at a time. Allocate-given and free
//   pass through the modify-write state and then the done state; skipped
//   actions go straight to done. Allocate-first streams the bitmap memory one
//   word per cycle through its single read port, up to the word holding the
//   free frame or the last word in range, at most
//   ceil(min(frame_count, 4096) / 32) = 128 words.
//   The engine goes back to idle once its response is taken.
// Reset
//   arst_n clears control state and the per-row valid bits of the bitmap,
//   so every frame reads as free at once; no clearing pass is run.
//   frame_count returns to 4096.
// Back-pressure
//   A finished response is parked in the output register, so the engine can
//   take the next request while rsp_stall is held; a second response waits
//   in the engine until the register drains.
`default_nettype none
module frame_bitmap_allocator (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_wr_en,
	input  wire logic [fba_pkg::FCNT_W-1:0]  cfg_wr_data,
	input  wire logic                        req_valid,
	output logic                             req_stall,
	input  wire fba_pkg::req_t               req,
	output logic                             rsp_valid,
	input  wire logic                        rsp_stall,
	output fba_pkg::rsp_t                    rsp
);
	import fba_pkg::*;

	logic [FCNT_W-1:0] frame_count_q;
	logic              rsp_valid_q;
	rsp_t              rsp_q;

	logic              eng_valid;
	logic              eng_stall;
	rsp_t              eng_res;
	logic              rsp_load;
	mem_req_t          mem_req;
	word_t             mem_rd_data;

	// Hold the frame count; the user must write it only between transactions, which the block does not enforce
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_count_q <= FRAME_COUNT_RESET;
		end else if (cfg_wr_en) begin
			frame_count_q <= cfg_wr_data;
		end
	end

	fba_bitmap_mem u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (mem_req),
		.rd_data (mem_rd_data)
	);

	fba_engine u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.frame_count (frame_count_q),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.req         (req),
		.res_valid   (eng_valid),
		.res_stall   (eng_stall),
		.res         (eng_res),
		.mem_req     (mem_req),
		.mem_rd_data (mem_rd_data)
	);

	// Output register: load when empty or being drained this cycle
	assign eng_stall = rsp_valid_q && rsp_stall;
	assign rsp_load  = eng_valid && !eng_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) rsp_q <= eng_res;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Only a successful allocation carries page-entry flags
	a_flags_only_on_alloc: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && (rsp.status != STATUS_DONE)) |-> (!rsp.present && !rsp.writable && !rsp.user_page))
		else $error("page flags set on a response that is not an allocation");

	// Running out of frames only happens for an unmapped entry
	a_no_free_unmapped: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && (rsp.status == STATUS_NO_FREE)) |-> (rsp.new_frame == '0))
		else $error("no-free response with a nonzero frame");

	// The scan never reads the row it is writing back in the same cycle
	a_no_rw_collision: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_req.wr_en && mem_req.rd_en) |-> (mem_req.wr_addr != mem_req.rd_addr))
		else $error("bitmap read and write hit the same row");

	// An accepted request holds the engine busy on the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> req_stall)
		else $error("engine took a request without going busy");

endmodule
`default_nettype wire

### bench/frame_bitmap_allocator_test.sv
// Self-checking testbench of the frame bitmap allocator: directed rows, then random phases.
module frame_bitmap_allocator_test;
	import fba_pkg::*;

	// The fourth action code has no name in the package; the block treats it as a no-op.
	localparam logic [1:0] ACT_RESERVED = 2'd3;

	// Slowest legal run: roughly 1500 transactions, each with a full scan, a sender gap
	// and stalled cycles; CYCLE_LIMIT bounds the run before it is called a hang.
	localparam int CYCLE_LIMIT  = 1_500_000;
	// Settle time after the last response: one full-depth scan plus margin.
	localparam int DRAIN_CYCLES = 140;
	localparam int PHASE_ITEMS  = 145;
	localparam int NUM_PHASES   = 10;

	typedef enum int {STALL_NONE, STALL_HOLD, STALL_CHOPPY} stall_mode_t;

	// One row of the directed part: either a frame_count write or a request, the latter
	// optionally carrying a hand-written expectation.
	typedef struct {
		bit                is_cfg;
		logic [FCNT_W-1:0] cfg_value;
		req_t              item;
		bit                typed;
		rsp_t              want;
	} dir_row_t;

	logic              clk;
	logic              arst_n      = 1'b0;
	logic              cfg_wr_en   = 1'b0;
	logic [FCNT_W-1:0] cfg_wr_data = '0;
	logic              req_valid   = 1'b0;
	logic              req_stall;
	req_t              req         = '0;
	logic              rsp_valid;
	logic              rsp_stall   = 1'b0;
	rsp_t              rsp;

	// Shadow of the block: usage bitmap and frame_count register.
	logic [NUM_FRAMES-1:0] frame_used;
	logic [FCNT_W-1:0]     frame_count_cfg;

	rsp_t               pending_rsp[$];   // responses still owed by the block, oldest first
	logic [FRAME_W-1:0] mapped_frames[$]; // frames held by page entries that may be freed
	dir_row_t           dir_rows[$];

	int          mismatch_count = 0;
	int          cycle_count    = 0;
	int          burst_left     = 0;
	int          stall_left     = 0;
	stall_mode_t stall_mode     = STALL_NONE;

	// frame_count per random phase: both extremes of the field, partial final words,
	// and the bitmap size with the value just below it.
	int phase_fc[NUM_PHASES] = '{4096, 40, 0, 1, 33, 8191, 100, 4095, 64, 4096};

	frame_bitmap_allocator u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.req         (req),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.rsp         (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Work out the response to one request and advance the shadow bitmap.
	function automatic rsp_t alloc_predict(req_t r);
		rsp_t o;
		int   lim;
		int   i;
		bit   found;
		o = '0;
		o.new_frame = r.current_frame;
		o.status = STATUS_SKIPPED;
		if ((r.action == ACT_ALLOC_FIRST || r.action == ACT_ALLOC_GIVEN) &&
				r.current_frame == '0) begin
			found = 1'b1;
			o.new_frame = r.given_frame;
			if (r.action == ACT_ALLOC_FIRST) begin
				// Scan no further than frame_count, the bitmap and the frame field allow.
				lim = int'(frame_count_cfg);
				if (lim > SCAN_LIMIT)
					lim = SCAN_LIMIT;
				found = 1'b0;
				for (i = 0; i < lim && !found; i++)
					if (!frame_used[i]) begin
						found = 1'b1;
						o.new_frame = FRAME_W'(i);
					end
			end
			if (found) begin
				// An allocate-given neither tests the bit nor respects frame_count.
				if (int'(o.new_frame) < NUM_FRAMES)
					frame_used[o.new_frame] = 1'b1;
				o.present = 1'b1;
				o.writable = r.rw_request;
				o.user_page = ~r.kernel_page;
				o.status = STATUS_DONE;
			end else begin
				o.new_frame = r.current_frame;
				o.status = STATUS_NO_FREE;
			end
		end else if (r.action == ACT_FREE && r.current_frame != '0) begin
			// The bit is cleared whether or not it was set.
			if (int'(r.current_frame) < NUM_FRAMES)
				frame_used[r.current_frame] = 1'b0;
			o.new_frame = '0;
			o.status = STATUS_DONE;
		end
		return o;
	endfunction

	function automatic dir_row_t row_item(logic [1:0] action, logic [FRAME_W-1:0] cur,
			logic [FRAME_W-1:0] given, logic kern, logic wr);
		dir_row_t d;
		d = '{default: '0};
		d.item = '{action: action, current_frame: cur, given_frame: given,
			kernel_page: kern, rw_request: wr};
		return d;
	endfunction

	function automatic dir_row_t row_check(logic [1:0] action, logic [FRAME_W-1:0] cur,
			logic [FRAME_W-1:0] given, logic kern, logic wr, logic [FRAME_W-1:0] nf,
			logic p, logic w, logic u, logic [1:0] st);
		dir_row_t d;
		d = row_item(action, cur, given, kern, wr);
		d.typed = 1'b1;
		d.want = '{new_frame: nf, present: p, writable: w, user_page: u, status: st};
		return d;
	endfunction

	function automatic dir_row_t row_cfg(int value);
		dir_row_t d;
		d = '{default: '0};
		d.is_cfg = 1'b1;
		d.cfg_value = FCNT_W'(value);
		return d;
	endfunction

	// Present one request and hold it until the block takes it. Requests go out in bursts
	// of random length; drop valid for a random gap between bursts.
	task automatic issue(req_t r, bit typed, rsp_t want);
		rsp_t predicted;
		if (burst_left == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(8, 1)) @(posedge clk);
			burst_left = ($urandom_range(4) == 0) ? $urandom_range(60, 20) : $urandom_range(10, 1);
		end
		req <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		predicted = alloc_predict(r);
		pending_rsp.push_back(typed ? want : predicted);
		// Remember the frame a page entry now holds so a later free can target it.
		if ((r.action == ACT_ALLOC_FIRST || r.action == ACT_ALLOC_GIVEN) &&
				r.current_frame == '0 && predicted.status == STATUS_DONE &&
				predicted.new_frame != '0)
			mapped_frames.push_back(predicted.new_frame);
		burst_left--;
	endtask

	// Write frame_count with the block idle: hold off until every response has drained,
	// which also gives the pause with nothing in flight.
	task automatic write_frame_count(int value);
		req_valid <= 1'b0;
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= FCNT_W'(value);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		frame_count_cfg = FCNT_W'(value);
		burst_left = 0;
	endtask

	// Mostly well-formed page traffic: allocate into unmapped entries and free entries that
	// hold a frame. The remainder is noise with every field random, reserved action included.
	task automatic random_item(output req_t r);
		int roll;
		int pick;
		r = '0;
		roll = $urandom_range(99);
		r.given_frame = $urandom_range(1) ? FRAME_W'($urandom_range(4095)) :
			FRAME_W'($urandom_range(63));
		r.kernel_page = 1'($urandom_range(1));
		r.rw_request = 1'($urandom_range(1));
		if (roll < 55) begin
			r.action = ACT_ALLOC_FIRST;
		end else if (roll < 80 && mapped_frames.size() != 0) begin
			pick = $urandom_range(mapped_frames.size() - 1);
			r.action = ACT_FREE;
			r.current_frame = mapped_frames[pick];
			mapped_frames.delete(pick);
		end else if (roll < 88) begin
			r.action = ACT_ALLOC_GIVEN;
		end else begin
			r.action = 2'($urandom_range(3));
			r.current_frame = ($urandom_range(3) == 0) ? '0 : FRAME_W'($urandom_range(4095));
		end
	endtask

	// Receiver back-pressure: calm stretches, solid holds and choppy spells.
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode = stall_mode_t'($urandom_range(2));
			case (stall_mode)
				STALL_NONE: stall_left = $urandom_range(200, 30);
				STALL_HOLD: stall_left = $urandom_range(6, 1);
				default:    stall_left = $urandom_range(80, 10);
			endcase
		end
		stall_left--;
		case (stall_mode)
			STALL_NONE: rsp_stall <= 1'b0;
			STALL_HOLD: rsp_stall <= 1'b1;
			default:    rsp_stall <= ($urandom_range(2) == 0);
		endcase
	end

	// Compare each accepted response transaction with the oldest one owed.
	always @(posedge clk) begin
		rsp_t want;
		if (rsp_valid && !rsp_stall) begin
			if (pending_rsp.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected response: new_frame %h status %0d", rsp.new_frame,
						rsp.status);
			end else begin
				want = pending_rsp.pop_front();
				if (rsp.new_frame !== want.new_frame || rsp.present !== want.present ||
						rsp.writable !== want.writable || rsp.user_page !== want.user_page ||
						rsp.status !== want.status) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("mismatch: exp %h p%b w%b u%b st%0d got %h p%b w%b u%b st%0d",
							want.new_frame, want.present, want.writable, want.user_page,
							want.status, rsp.new_frame, rsp.present, rsp.writable,
							rsp.user_page, rsp.status);
				end
			end
		end
	end

	// Watchdog: a run this long means the block has hung.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("frame_bitmap_allocator_test NOT OK");
			$finish;
		end
	end

	initial begin
		req_t item;
		int   p;
		int   n;
		frame_used = '0;
		frame_count_cfg = FRAME_COUNT_RESET;

		// Directed part. After reset every frame is free and frame_count is 4096.
		dir_rows.push_back(row_check(ACT_ALLOC_FIRST, 12'h000, 12'h000, 1'b0, 1'b1,
			12'h000, 1'b1, 1'b1, 1'b1, STATUS_DONE));
		dir_rows.push_back(row_check(ACT_ALLOC_FIRST, 12'h000, 12'hFFF, 1'b1, 1'b0,
			12'h001, 1'b1, 1'b0, 1'b0, STATUS_DONE));
		// Entry already mapped: allocation skipped, flags clear.
		dir_rows.push_back(row_check(ACT_ALLOC_FIRST, 12'hFFF, 12'h000, 1'b0, 1'b1,
			12'hFFF, 1'b0, 1'b0, 1'b0, STATUS_SKIPPED));
		dir_rows.push_back(row_check(ACT_ALLOC_GIVEN, 12'h000, 12'hFFF, 1'b0, 1'b1,
			12'hFFF, 1'b1, 1'b1, 1'b1, STATUS_DONE));
		// Frame 0 handed out again: the given path does not test the bit.
		dir_rows.push_back(row_check(ACT_ALLOC_GIVEN, 12'h000, 12'h000, 1'b1, 1'b1,
			12'h000, 1'b1, 1'b1, 1'b0, STATUS_DONE));
		dir_rows.push_back(row_check(ACT_ALLOC_GIVEN, 12'h005, 12'h007, 1'b0, 1'b0,
			12'h005, 1'b0, 1'b0, 1'b0, STATUS_SKIPPED));
		// Free of an unmapped entry.
		dir_rows.push_back(row_check(ACT_FREE, 12'h000, 12'hFFF, 1'b1, 1'b1,
			12'h000, 1'b0, 1'b0, 1'b0, STATUS_SKIPPED));
		dir_rows.push_back(row_check(ACT_FREE, 12'h001, 12'h000, 1'b0, 1'b0,
			12'h000, 1'b0, 1'b0, 1'b0, STATUS_DONE));
		dir_rows.push_back(row_item(ACT_ALLOC_FIRST, 12'h000, 12'h000, 1'b1, 1'b1));
		// Reserved action does nothing.
		dir_rows.push_back(row_check(ACT_RESERVED, 12'hABC, 12'h123, 1'b1, 1'b1,
			12'hABC, 1'b0, 1'b0, 1'b0, STATUS_SKIPPED));
		dir_rows.push_back(row_check(ACT_RESERVED, 12'h000, 12'hFFF, 1'b0, 1'b1,
			12'h000, 1'b0, 1'b0, 1'b0, STATUS_SKIPPED));
		dir_rows.push_back(row_check(ACT_FREE, 12'hFFF, 12'h000, 1'b1, 1'b0,
			12'h000, 1'b0, 1'b0, 1'b0, STATUS_DONE));
		dir_rows.push_back(row_item(ACT_FREE, 12'h800, 12'h000, 1'b0, 1'b1));
		dir_rows.push_back(row_item(ACT_ALLOC_GIVEN, 12'h000, 12'h555, 1'b1, 1'b1));
		dir_rows.push_back(row_item(ACT_ALLOC_FIRST, 12'h000, 12'hFFF, 1'b0, 1'b0));
		// No frames managed at all: nothing free.
		dir_rows.push_back(row_cfg(0));
		dir_rows.push_back(row_check(ACT_ALLOC_FIRST, 12'h000, 12'h000, 1'b0, 1'b1,
			12'h000, 1'b0, 1'b0, 1'b0, STATUS_NO_FREE));
		dir_rows.push_back(row_item(ACT_ALLOC_GIVEN, 12'h000, 12'h003, 1'b0, 1'b0));
		// Frames 0..2 all taken and frame 3 lies beyond the limit.
		dir_rows.push_back(row_cfg(3));
		dir_rows.push_back(row_check(ACT_ALLOC_FIRST, 12'h000, 12'h000, 1'b1, 1'b1,
			12'h000, 1'b0, 1'b0, 1'b0, STATUS_NO_FREE));
		dir_rows.push_back(row_item(ACT_FREE, 12'h002, 12'h000, 1'b0, 1'b0));
		dir_rows.push_back(row_item(ACT_ALLOC_FIRST, 12'h000, 12'h000, 1'b0, 1'b1));
		// Register maximum: scan clamps to the bitmap.
		dir_rows.push_back(row_cfg(8191));
		dir_rows.push_back(row_item(ACT_ALLOC_FIRST, 12'h000, 12'hFFF, 1'b1, 1'b0));

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[k]) begin
			if (dir_rows[k].is_cfg)
				write_frame_count(dir_rows[k].cfg_value);
			else
				issue(dir_rows[k].item, dir_rows[k].typed, dir_rows[k].want);
		end

		// Random phases, each under its own frame_count; the bitmap carries over.
		for (p = 0; p < NUM_PHASES; p++) begin
			write_frame_count(phase_fc[p]);
			for (n = 0; n < PHASE_ITEMS; n++) begin
				random_item(item);
				issue(item, 1'b0, '0);
			end
		end

		// Drain, then give the block time to show any stray response.
		req_valid <= 1'b0;
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_rsp.size() == 0)
			$display("frame_bitmap_allocator_test OK");
		else
			$display("frame_bitmap_allocator_test NOT OK");
		$finish;
	end

endmodule
